// ===== src/jdcd_pkg.sv =====
// Constants, tables and types for the Julian day number to calendar date converter.
// No dependencies.

package jdcd_pkg;

    localparam int unsigned DayWidth   = 32;
    localparam int unsigned YearWidth  = 24;
    localparam int unsigned DoyWidth   = 9;

    // calendar switch and epochs
    localparam logic [31:0] LastJulianDay = 32'd2299160;
    localparam logic [31:0] GregEpochDay  = 32'd2159717;  // 1 January 1201
    localparam logic [23:0] GregEpochYear = 24'd1201;
    localparam logic [12:0] JulianYearOfs = 13'd4712;

    localparam logic [17:0] Days400 = 18'd146097;
    localparam logic [15:0] Days100 = 16'd36524;
    localparam logic [10:0] Days4   = 11'd1461;
    localparam logic [8:0]  Days1   = 9'd365;

    // floor(2^k / divisor) for quotient estimates that are low by at most one
    localparam logic [14:0] Recip400 = 15'd29398;  // k = 32
    localparam logic [11:0] Recip4J  = 12'd2870;   // k = 22
    localparam logic [5:0]  Recip4G  = 6'd44;      // k = 16

    localparam logic [8:0] MonthStart [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // day of year, leap flag, absolute year and era
    typedef struct packed {
        logic [8:0]  doy;
        logic        leap;
        logic [23:0] year;
        logic        bc;
    } date_part_t;

endpackage

// ===== src/julian_day_to_calendar_date.sv =====
// Julian day number to civil date: 11 register stages, one transaction per cycle while day_stall is low.
// Each transaction passes through the stages in order; its result is presented from the stage 11 output register.
// Each stage holds its item while the next is full and stalled; bubbles are filled,
// so input is stalled only when all 11 stages hold items and the output is stalled.
// rst_n (asynchronous, active low) clears all stage valid bits; data registers are not reset.
// Depends on jdcd_pkg.

module julian_day_to_calendar_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        day_valid,
    output logic        day_stall,
    input  logic [31:0] julian_day,
    output logic        date_valid,
    input  logic        date_stall,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [23:0] year_number,
    output logic        before_christ
);

    localparam int unsigned NStage = 11;

    logic [NStage:1] v_reg;
    logic [NStage:1] rdy;

    always_comb
    begin
        rdy[NStage] = !v_reg[NStage] || !date_stall;
        for (int k = NStage - 1; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
    end

    assign day_stall  = !rdy[1];
    assign date_valid = v_reg[NStage];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= day_valid;
            end
            for (int k = 2; k <= NStage; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
        end
    end

    // ---------------- stage 1: split on calendar, offset to Gregorian epoch
    logic        s1_greg_reg;
    logic [31:0] s1_d_reg;
    logic [21:0] s1_jd_reg;

    // ---------------- stage 2: quotient estimates
    logic        s2_greg_reg;
    logic [31:0] s2_d_reg;
    logic [21:0] s2_jd_reg;
    logic [14:0] s2_q400_reg;
    logic [10:0] s2_cyc_reg;
    logic [46:0] p400;
    logic [33:0] pj;

    assign p400 = 47'(s1_d_reg) * 47'(jdcd_pkg::Recip400);
    assign pj   = 34'(s1_jd_reg) * 34'(jdcd_pkg::Recip4J);

    // ---------------- stage 3: raw remainders
    logic        s3_greg_reg;
    logic [14:0] s3_q400_reg;
    logic [10:0] s3_cyc_reg;
    logic [18:0] s3_r400_reg;
    logic [11:0] s3_rj_reg;
    logic [31:0] m400;
    logic [21:0] mj;

    assign m400 = 32'(33'(s2_q400_reg) * 33'(jdcd_pkg::Days400));
    assign mj   = 22'(22'(s2_cyc_reg) * 22'(jdcd_pkg::Days4));

    // ---------------- stage 4: quotient correction
    logic        s4_greg_reg;
    logic [14:0] s4_q400_reg;
    logic [17:0] s4_r400_reg;
    logic [10:0] s4_cyc_reg;
    logic [10:0] s4_rj_reg;
    logic        r400_over;
    logic        rj_over;

    assign r400_over = s3_r400_reg >= 19'(jdcd_pkg::Days400);
    assign rj_over   = s3_rj_reg >= 12'(jdcd_pkg::Days4);

    // ---------------- stage 5: century split; Julian date finished
    logic                 s5_greg_reg;
    logic [1:0]           s5_c_reg;
    logic [15:0]          s5_r100_reg;
    logic [23:0]          s5_ybase_reg;
    jdcd_pkg::date_part_t s5_jul_reg;
    logic [1:0]           c_next;
    logic [1:0]           yj;
    logic [8:0]           yj_ofs;
    logic [12:0]          yv;
    jdcd_pkg::date_part_t jul_next;

    always_comb
    begin
        if (s4_r400_reg >= 18'(3 * jdcd_pkg::Days100))
        begin
            c_next = 2'd3;
        end
        else if (s4_r400_reg >= 18'(2 * jdcd_pkg::Days100))
        begin
            c_next = 2'd2;
        end
        else if (s4_r400_reg >= 18'(jdcd_pkg::Days100))
        begin
            c_next = 2'd1;
        end
        else
        begin
            c_next = 2'd0;
        end

        // Julian 4-year cycle opens with its leap year
        if (s4_rj_reg < 11'd366)
        begin
            yj     = 2'd0;
            yj_ofs = 9'd0;
        end
        else if (s4_rj_reg < 11'd731)
        begin
            yj     = 2'd1;
            yj_ofs = 9'd366;
        end
        else if (s4_rj_reg < 11'd1096)
        begin
            yj     = 2'd2;
            yj_ofs = 9'd365;
        end
        else
        begin
            yj     = 2'd3;
            yj_ofs = 9'd0;
        end

        yv            = {s4_cyc_reg, 2'b00} + 13'(yj);
        jul_next.leap = (yj == 2'd0);
        jul_next.bc   = (yv <= jdcd_pkg::JulianYearOfs);
        jul_next.year = jul_next.bc ? 24'(jdcd_pkg::JulianYearOfs + 13'd1 - yv)
                                    : 24'(yv - jdcd_pkg::JulianYearOfs);
        // the 731 offset exceeds 9 bits, so it is subtracted in two parts; 1096 is subtracted directly
        case (yj)
            2'd0:    jul_next.doy = 9'(s4_rj_reg);
            2'd1:    jul_next.doy = 9'(s4_rj_reg - 11'(yj_ofs));
            2'd2:    jul_next.doy = 9'(s4_rj_reg - 11'd366 - 11'(yj_ofs));
            default: jul_next.doy = 9'(s4_rj_reg - 11'd1096);
        endcase
    end

    // ---------------- stage 6: 4-year quotient estimate
    logic                 s6_greg_reg;
    logic                 s6_c3_reg;
    logic [15:0]          s6_r100_reg;
    logic [4:0]           s6_q4_reg;
    logic [23:0]          s6_ybase_reg;
    jdcd_pkg::date_part_t s6_jul_reg;
    logic [21:0]          p4;

    assign p4 = 22'(s5_r100_reg) * 22'(jdcd_pkg::Recip4G);

    // ---------------- stage 7: raw 4-year remainder
    logic                 s7_greg_reg;
    logic                 s7_c3_reg;
    logic [4:0]           s7_q4_reg;
    logic [11:0]          s7_r4_reg;
    logic [23:0]          s7_ybase_reg;
    jdcd_pkg::date_part_t s7_jul_reg;
    logic [15:0]          m4;

    assign m4 = 16'(16'(s6_q4_reg) * 16'(jdcd_pkg::Days4));

    // ---------------- stage 8: 4-year correction
    logic                 s8_greg_reg;
    logic                 s8_c3_reg;
    logic [4:0]           s8_q4_reg;
    logic [10:0]          s8_r4_reg;
    logic [23:0]          s8_ybase_reg;
    jdcd_pkg::date_part_t s8_jul_reg;
    logic                 r4_over;

    assign r4_over = s7_r4_reg >= 12'(jdcd_pkg::Days4);

    // ---------------- stage 9: year within cycle, calendar select
    jdcd_pkg::date_part_t s9_date_reg;
    jdcd_pkg::date_part_t greg_next;
    logic [1:0]           yg;

    always_comb
    begin
        // last day of a leap 4-year block lands on year index 4; clamp to 3
        if (s8_r4_reg >= 11'(3 * jdcd_pkg::Days1))
        begin
            yg = 2'd3;
        end
        else if (s8_r4_reg >= 11'(2 * jdcd_pkg::Days1))
        begin
            yg = 2'd2;
        end
        else if (s8_r4_reg >= 11'(jdcd_pkg::Days1))
        begin
            yg = 2'd1;
        end
        else
        begin
            yg = 2'd0;
        end
        greg_next.doy  = 9'(s8_r4_reg - 11'(11'(yg) * 11'(jdcd_pkg::Days1)));
        // century years are leap only when also divisible by 400
        greg_next.leap = (yg == 2'd3) && ((s8_q4_reg != 5'd24) || s8_c3_reg);
        greg_next.year = s8_ybase_reg + 24'({s8_q4_reg, 2'b00}) + 24'(yg);
        greg_next.bc   = 1'b0;
    end

    // ---------------- stage 10: month lookup
    jdcd_pkg::date_part_t s10_date_reg;
    logic [3:0]           s10_mon_reg;
    logic [8:0]           s10_mstart_reg;
    logic [3:0]           midx;
    logic [8:0]           mstart;

    always_comb
    begin
        midx = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (s9_date_reg.doy >= jdcd_pkg::MonthStart[m]
                + 9'((s9_date_reg.leap && (m >= 2)) ? 1 : 0))
            begin
                midx = 4'(m);
            end
        end
        mstart = jdcd_pkg::MonthStart[midx]
                 + 9'((s9_date_reg.leap && (midx >= 4'd2)) ? 1 : 0);
    end

    // ---------------- stage 11: output register
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [23:0] year_reg;
    logic        bc_reg;

    assign day_of_month  = day_reg;
    assign month_number  = month_reg;
    assign year_number   = year_reg;
    assign before_christ = bc_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_greg_reg <= julian_day > jdcd_pkg::LastJulianDay;
            s1_d_reg    <= julian_day - jdcd_pkg::GregEpochDay;
            s1_jd_reg   <= julian_day[21:0];
        end
        if (rdy[2])
        begin
            s2_greg_reg <= s1_greg_reg;
            s2_d_reg    <= s1_d_reg;
            s2_jd_reg   <= s1_jd_reg;
            s2_q400_reg <= p400[46:32];
            s2_cyc_reg  <= pj[32:22];
        end
        if (rdy[3])
        begin
            s3_greg_reg <= s2_greg_reg;
            s3_q400_reg <= s2_q400_reg;
            s3_cyc_reg  <= s2_cyc_reg;
            s3_r400_reg <= 19'(s2_d_reg - m400);
            s3_rj_reg   <= 12'(s2_jd_reg - mj);
        end
        if (rdy[4])
        begin
            s4_greg_reg <= s3_greg_reg;
            s4_q400_reg <= s3_q400_reg + 15'(r400_over);
            s4_r400_reg <= r400_over ? 18'(s3_r400_reg - 19'(jdcd_pkg::Days400))
                                     : 18'(s3_r400_reg);
            s4_cyc_reg  <= s3_cyc_reg + 11'(rj_over);
            s4_rj_reg   <= rj_over ? 11'(s3_rj_reg - 12'(jdcd_pkg::Days4))
                                   : 11'(s3_rj_reg);
        end
        if (rdy[5])
        begin
            s5_greg_reg  <= s4_greg_reg;
            s5_c_reg     <= c_next;
            s5_r100_reg  <= 16'(s4_r400_reg - 18'(18'(c_next) * 18'(jdcd_pkg::Days100)));
            s5_ybase_reg <= jdcd_pkg::GregEpochYear + 24'(24'(s4_q400_reg) * 24'd400);
            s5_jul_reg   <= jul_next;
        end
        if (rdy[6])
        begin
            s6_greg_reg  <= s5_greg_reg;
            s6_c3_reg    <= (s5_c_reg == 2'd3);
            s6_r100_reg  <= s5_r100_reg;
            s6_q4_reg    <= p4[20:16];
            s6_ybase_reg <= s5_ybase_reg + 24'(24'(s5_c_reg) * 24'd100);
            s6_jul_reg   <= s5_jul_reg;
        end
        if (rdy[7])
        begin
            s7_greg_reg  <= s6_greg_reg;
            s7_c3_reg    <= s6_c3_reg;
            s7_q4_reg    <= s6_q4_reg;
            s7_r4_reg    <= 12'(s6_r100_reg - m4);
            s7_ybase_reg <= s6_ybase_reg;
            s7_jul_reg   <= s6_jul_reg;
        end
        if (rdy[8])
        begin
            s8_greg_reg  <= s7_greg_reg;
            s8_c3_reg    <= s7_c3_reg;
            s8_q4_reg    <= s7_q4_reg + 5'(r4_over);
            s8_r4_reg    <= r4_over ? 11'(s7_r4_reg - 12'(jdcd_pkg::Days4))
                                    : 11'(s7_r4_reg);
            s8_ybase_reg <= s7_ybase_reg;
            s8_jul_reg   <= s7_jul_reg;
        end
        if (rdy[9])
        begin
            s9_date_reg <= s8_greg_reg ? greg_next : s8_jul_reg;
        end
        if (rdy[10])
        begin
            s10_date_reg   <= s9_date_reg;
            s10_mon_reg    <= midx + 4'd1;
            s10_mstart_reg <= mstart;
        end
        if (rdy[11])
        begin
            day_reg   <= 5'(s10_date_reg.doy - s10_mstart_reg + 9'd1);
            month_reg <= s10_mon_reg;
            year_reg  <= s10_date_reg.year;
            bc_reg    <= s10_date_reg.bc;
        end
    end

    // input backs up only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        day_stall |-> (date_valid && date_stall && (&v_reg)))
        else $error("input stalled with a free stage");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> ((month_number >= 4'd1) && (month_number <= 4'd12)
                        && (day_of_month != 5'd0) && (year_number != 24'd0)))
        else $error("date out of range");

    a_bc_year: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && before_christ) |-> (year_number <= 24'd4713))
        else $error("BC year beyond 4713");

    a_leap_day: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && (month_number == 4'd2)) |-> (day_of_month <= 5'd29))
        else $error("February day beyond 29");

endmodule
